// ===== hw/rtl/sgc_pkg.sv =====
// ----------------------------------------------------------------------------
// sgc_pkg: servo grip controller shared definitions
// Field widths, register indexes, action codes, tuning constants, the
// result record and the pulse to angle mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgc_pkg;

    // field widths
    localparam int ACTION_W   = 2;
    localparam int SAMPLE_W   = 12;
    localparam int MS_W       = 8;
    localparam int PULSE_W    = 12;
    localparam int ANGLE_W    = 8;
    localparam int STEP_W     = 8;
    localparam int GAIN_W     = 24;
    localparam int OFFSET_W   = 17;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // state widths
    localparam int FILT_W     = 28;
    localparam int STEPV_W    = 9;
    localparam int IDLE_W     = 16;
    localparam int OBS_MS_W   = 12;
    localparam int RELAX_MS_W = 8;

    // fixed point formats of the feedback mapping
    localparam int GAIN_FRAC   = 16;
    localparam int OFFSET_FRAC = 8;

    // tuning
    localparam int FILTER_SHIFT_DEF    = 6;
    localparam int OBSTACLE_DELTA      = 5;
    localparam int OBSTACLE_DELTA_HARD = 15;
    localparam int RELAX_DELTA         = 3;
    localparam int PULSE_AT_ZERO       = 544;
    localparam int PULSE_AT_FULL       = 2400;
    localparam int OBSTACLE_HOLD_MS    = 2000;
    localparam int RELAX_PERIOD_MS     = 50;
    localparam int ANGLE_SPAN          = 180;

    // register reset values
    localparam logic [PULSE_W-1:0]   PULSE_MIN_RST    = PULSE_W'(1000);
    localparam logic [PULSE_W-1:0]   PULSE_MAX_RST    = PULSE_W'(2000);
    localparam logic [STEP_W-1:0]    STEP_SPEED_RST   = STEP_W'(1);
    localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = TIMEOUT_W'(1000);
    localparam logic [PULSE_W-1:0]   PULSE_RST        =
        PULSE_W'((1000 + 2000) / 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_MIN    = 3'd0,
        REG_PULSE_MAX    = 3'd1,
        REG_STEP_SPEED   = 3'd2,
        REG_HAND_SIDE    = 3'd3,
        REG_FB_GAIN      = 3'd4,
        REG_FB_OFFSET    = 3'd5,
        REG_IDLE_TIMEOUT = 3'd6
    } cfg_reg_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic               pulse_write;
        logic [ANGLE_W-1:0] servo_angle;
        logic [ANGLE_W-1:0] feedback_angle;
        logic               obstacle;
        logic               detached;
        logic               relaxed;
    } sgc_result_t;

    // pulse to angle: multiply by a rounded-up reciprocal, exact over the pulse range
    localparam int SERVO_SPAN  = (PULSE_AT_FULL > PULSE_AT_ZERO) ?
                                 (PULSE_AT_FULL - PULSE_AT_ZERO) : 1;
    localparam int SCALED_W    = PULSE_W + 8;
    localparam int RECIP_SHIFT = 32;
    localparam longint unsigned ANGLE_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(SERVO_SPAN) - 64'd1) / 64'(SERVO_SPAN);

    function automatic logic [ANGLE_W-1:0] pulse_to_angle(input logic [PULSE_W-1:0] p);
        logic [PULSE_W-1:0]  x;
        logic [SCALED_W-1:0] n;
        logic [63:0]         prod;
        logic [ANGLE_W-1:0]  a;
        x    = p - PULSE_W'(PULSE_AT_ZERO);
        n    = SCALED_W'(x) * SCALED_W'(ANGLE_SPAN);
        prod = 64'(n) * ANGLE_RECIP;
        if (PULSE_AT_FULL <= PULSE_AT_ZERO)
        begin
            a = (p >= PULSE_W'(PULSE_AT_FULL)) ? ANGLE_W'(ANGLE_SPAN) : '0;
        end
        else if (p <= PULSE_W'(PULSE_AT_ZERO))
        begin
            a = '0;
        end
        else if (p >= PULSE_W'(PULSE_AT_FULL))
        begin
            a = ANGLE_W'(ANGLE_SPAN);
        end
        else
        begin
            a = ANGLE_W'(prod >> RECIP_SHIFT);
        end
        return a;
    endfunction

endpackage

// ===== hw/rtl/sgc_if.sv =====
// ----------------------------------------------------------------------------
// sgc_if: servo grip controller channel interfaces
// Valid/ready channels for command and tick items and for result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sgc_req_if;
    import sgc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SAMPLE_W-1:0] feedback_sample;
    logic [MS_W-1:0]     ms_elapsed;

    modport source (output valid, action, feedback_sample, ms_elapsed, input ready);
    modport sink   (input valid, action, feedback_sample, ms_elapsed, output ready);
endinterface

interface sgc_rsp_if;
    import sgc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_width;
    logic               pulse_write;
    logic [ANGLE_W-1:0] servo_angle;
    logic [ANGLE_W-1:0] feedback_angle;
    logic               obstacle;
    logic               detached;
    logic               relaxed;

    modport source (output valid, pulse_width, pulse_write, servo_angle, feedback_angle,
                    obstacle, detached, relaxed, input ready);
    modport sink   (input valid, pulse_width, pulse_write, servo_angle, feedback_angle,
                    obstacle, detached, relaxed, output ready);
endinterface

// ===== hw/rtl/sgc_fb_angle.sv =====
// ----------------------------------------------------------------------------
// sgc_fb_angle: feedback filter and angle mapping
// First-order low-pass filter on the feedback samples and a linear map of
// the filtered value to an angle saturated to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgc_fb_angle #(
    parameter int FILTER_SHIFT = sgc_pkg::FILTER_SHIFT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               update,
    input  logic [sgc_pkg::SAMPLE_W-1:0]       sample,
    input  logic signed [sgc_pkg::GAIN_W-1:0]  fb_gain,
    input  logic signed [sgc_pkg::OFFSET_W-1:0] fb_offset,
    output logic [sgc_pkg::ANGLE_W-1:0]        angle
);
    import sgc_pkg::*;

    localparam int ProdW = GAIN_W + FILT_W + 1;
    localparam int OffSh = GAIN_FRAC - OFFSET_FRAC + FILTER_SHIFT;
    localparam int OffW  = OFFSET_W + OffSh;
    localparam int SumW  = ((ProdW > OffW) ? ProdW : OffW) + 1;
    localparam int FracW = GAIN_FRAC + FILTER_SHIFT;

    logic [FILT_W-1:0]      filt_reg;
    logic [FILT_W-1:0]      filt_next;
    logic [FILT_W-1:0]      filt_cur;
    logic signed [ProdW-1:0] prod_s;
    logic signed [SumW-1:0]  off_s;
    logic signed [SumW-1:0]  sum_s;

    // f += sample - f / 2^shift, wrapping at the state width
    assign filt_next = filt_reg + FILT_W'(sample) - (filt_reg >> FILTER_SHIFT);
    assign filt_cur  = update ? filt_next : filt_reg;

    always_comb
    begin
        prod_s = fb_gain * $signed({1'b0, filt_cur});
        off_s  = SumW'(fb_offset) <<< OffSh;
        sum_s  = SumW'(prod_s) + off_s;
        if (sum_s[SumW-1])
        begin
            angle = '0;
        end
        else if (|sum_s[SumW-2:FracW+ANGLE_W])
        begin
            angle = '1;
        end
        else
        begin
            angle = sum_s[FracW+ANGLE_W-1:FracW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else if (update)
        begin
            filt_reg <= filt_next;
        end
    end

endmodule

// ===== hw/rtl/sgc_out_buf.sv =====
// ----------------------------------------------------------------------------
// sgc_out_buf: result output register with skid stage
// Holds result items for the receiver; a second entry catches an item
// that arrives while the output register is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgc_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sgc_pkg::sgc_result_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sgc_pkg::sgc_result_t out_data
);
    import sgc_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    sgc_result_t out_reg;
    sgc_result_t skid_reg;
    logic        in_fire;
    logic        out_fire;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= in_data;
            end
            else
            begin
                out_reg <= in_data;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("item arriving at a stalled output was not caught");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && out_reg == $past(skid_reg)))
        else $error("skid entry not moved to the output in order");

endmodule

// ===== hw/rtl/servo_grip_controller_unit.sv =====
// ----------------------------------------------------------------------------
// servo_grip_controller_unit: servo grip controller
// Open, close and stop commands and feedback ticks drive the servo pulse
// width with obstacle detection, idle detach and relaxing.
// ----------------------------------------------------------------------------
// Usage
//   req carries one item per transfer: an action (tick, open, close, stop),
//   a feedback ADC sample used on ticks and the milliseconds since the
//   previous item. Every item gives exactly one result item on rsp.
//   Registers are written through wr_en / wr_index / wr_data, one per cycle,
//   while no items are in flight; unknown indexes are ignored.
// Throughput
//   One item per cycle while rsp is not stalled. The whole update runs in the cycle of
//   the transfer (filter, feedback multiply, angle compare, pulse clamp) and the
//   result is registered in the output buffer before it appears on rsp.
// Reset
//   Registers take their default values, the pulse width starts at 1500,
//   the filter and all timers are cleared and both channels go empty.
// Stalls
//   A stalled result is held in the output register; one more item is still
//   taken into a skid entry, after which req.ready drops until the held
//   result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_grip_controller_unit #(
    parameter int FILTER_SHIFT = sgc_pkg::FILTER_SHIFT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sgc_req_if.sink                          req,
    sgc_rsp_if.source                        rsp,
    input  logic                             wr_en,
    input  logic [sgc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [sgc_pkg::CFG_DATA_W-1:0]   wr_data
);
    import sgc_pkg::*;

    // configuration
    logic [PULSE_W-1:0]         pulse_min_reg;
    logic [PULSE_W-1:0]         pulse_max_reg;
    logic [STEP_W-1:0]          step_speed_reg;
    logic                       hand_side_reg;
    logic signed [GAIN_W-1:0]   fb_gain_reg;
    logic signed [OFFSET_W-1:0] fb_offset_reg;
    logic [TIMEOUT_W-1:0]       idle_timeout_reg;

    // control state
    logic [PULSE_W-1:0]        pulse_reg,      pulse_next;
    logic                      moving_reg,     moving_next;
    logic signed [STEPV_W-1:0] step_value_reg, step_value_next;
    logic [IDLE_W-1:0]         idle_ms_reg,    idle_ms_next;
    logic                      armed_reg,      armed_next;
    logic [OBS_MS_W-1:0]       obs_ms_reg,     obs_ms_next;
    logic [RELAX_MS_W-1:0]     relax_ms_reg,   relax_ms_next;
    logic                      relaxed_reg,    relaxed_next;

    logic                      acc;
    logic                      is_tick;
    logic                      buf_ready;
    sgc_result_t               res_d;
    sgc_result_t               res_q;

    logic [ANGLE_W-1:0]        sangle;
    logic [ANGLE_W-1:0]        fangle;
    logic [IDLE_W:0]           idle_sum;
    logic [RELAX_MS_W:0]       relax_sum;
    logic [OBS_MS_W:0]         obs_sum;
    logic [IDLE_W-1:0]         idle_inc;
    logic [RELAX_MS_W-1:0]     relax_inc;
    logic [OBS_MS_W-1:0]       obs_base;
    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W-1:0]        adiff;
    logic signed [STEPV_W-1:0] dsign;
    logic signed [STEPV_W-1:0] delta;
    logic signed [PULSE_W+1:0] cand;
    logic [PULSE_W-1:0]        clamped;
    logic                      obs;
    logic                      det;
    logic                      plus;

    assign is_tick   = (req.action == ACT_TICK);
    assign acc       = req.valid && buf_ready;
    assign req.ready = buf_ready;

    sgc_fb_angle #(
        .FILTER_SHIFT (FILTER_SHIFT)
    ) u_fb_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .update    (acc && is_tick),
        .sample    (req.feedback_sample),
        .fb_gain   (fb_gain_reg),
        .fb_offset (fb_offset_reg),
        .angle     (fangle)
    );

    always_comb
    begin
        sangle    = pulse_to_angle(pulse_reg);

        // saturating timers
        idle_sum  = {1'b0, idle_ms_reg} + (IDLE_W+1)'(req.ms_elapsed);
        relax_sum = {1'b0, relax_ms_reg} + (RELAX_MS_W+1)'(req.ms_elapsed);
        obs_sum   = {1'b0, obs_ms_reg} + (OBS_MS_W+1)'(req.ms_elapsed);
        idle_inc  = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];
        relax_inc = relax_sum[RELAX_MS_W] ? '1 : relax_sum[RELAX_MS_W-1:0];
        obs_base  = armed_reg ? obs_ms_reg : (obs_sum[OBS_MS_W] ? '1 : obs_sum[OBS_MS_W-1:0]);

        diff  = $signed({1'b0, sangle}) - $signed({1'b0, fangle});
        adiff = diff[ANGLE_W] ? ANGLE_W'(-diff) : ANGLE_W'(diff);
        if (diff[ANGLE_W])
        begin
            dsign = -STEPV_W'(1);
        end
        else if (diff != '0)
        begin
            dsign = STEPV_W'(1);
        end
        else
        begin
            dsign = '0;
        end

        // one clamp unit: a moving step, or backing off against the angle error
        delta = moving_reg ? step_value_reg : -dsign;
        cand  = $signed({2'b00, pulse_reg}) + (PULSE_W+2)'(delta);
        if (cand < $signed({2'b00, pulse_min_reg}))
        begin
            clamped = pulse_min_reg;
        end
        else if (cand > $signed({2'b00, pulse_max_reg}))
        begin
            clamped = pulse_max_reg;
        end
        else
        begin
            clamped = cand[PULSE_W-1:0];
        end

        plus = (req.action == ACT_OPEN) ? hand_side_reg : !hand_side_reg;

        pulse_next      = pulse_reg;
        moving_next     = moving_reg;
        step_value_next = step_value_reg;
        idle_ms_next    = idle_inc;
        armed_next      = armed_reg;
        obs_ms_next     = obs_base;
        relax_ms_next   = relax_inc;
        relaxed_next    = relaxed_reg;
        obs             = 1'b0;
        det             = 1'b0;
        res_d.pulse_write = 1'b0;

        if (!is_tick)
        begin
            if (req.action == ACT_STOP)
            begin
                moving_next     = 1'b0;
                step_value_next = '0;
            end
            else
            begin
                moving_next     = 1'b1;
                step_value_next = plus ? $signed({1'b0, step_speed_reg})
                                       : -$signed({1'b0, step_speed_reg});
            end
            det = (idle_inc > idle_timeout_reg);
        end
        else
        begin
            if (adiff > ANGLE_W'(OBSTACLE_DELTA_HARD))
            begin
                obs = 1'b1;
            end
            else if (adiff > ANGLE_W'(OBSTACLE_DELTA))
            begin
                // first tick of a soft obstacle restarts the hold timer
                if (armed_reg)
                begin
                    obs_ms_next = '0;
                end
                armed_next = 1'b0;
                obs = (obs_ms_next > OBS_MS_W'(OBSTACLE_HOLD_MS));
            end
            else
            begin
                armed_next = 1'b1;
            end

            if (moving_reg)
            begin
                if (!obs || dsign != step_value_reg)
                begin
                    pulse_next = clamped;
                end
                idle_ms_next = '0;
            end
            else
            begin
                det = (idle_inc > idle_timeout_reg);
            end

            if (det)
            begin
                if (adiff > ANGLE_W'(RELAX_DELTA) && !relaxed_reg)
                begin
                    if (relax_inc > RELAX_MS_W'(RELAX_PERIOD_MS))
                    begin
                        pulse_next        = clamped;
                        res_d.pulse_write = 1'b1;
                        relax_ms_next     = '0;
                    end
                end
                else
                begin
                    relaxed_next = 1'b1;
                end
            end
            else
            begin
                res_d.pulse_write = 1'b1;
                relaxed_next      = 1'b0;
            end
        end

        res_d.pulse_width    = pulse_next;
        res_d.servo_angle    = sangle;
        res_d.feedback_angle = fangle;
        res_d.obstacle       = obs;
        res_d.detached       = det;
        res_d.relaxed        = relaxed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg    <= PULSE_MIN_RST;
            pulse_max_reg    <= PULSE_MAX_RST;
            step_speed_reg   <= STEP_SPEED_RST;
            hand_side_reg    <= 1'b0;
            fb_gain_reg      <= '0;
            fb_offset_reg    <= '0;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PULSE_MIN:    pulse_min_reg    <= wr_data[PULSE_W-1:0];
                REG_PULSE_MAX:    pulse_max_reg    <= wr_data[PULSE_W-1:0];
                REG_STEP_SPEED:   step_speed_reg   <= wr_data[STEP_W-1:0];
                REG_HAND_SIDE:    hand_side_reg    <= wr_data[0];
                REG_FB_GAIN:      fb_gain_reg      <= $signed(wr_data[GAIN_W-1:0]);
                REG_FB_OFFSET:    fb_offset_reg    <= $signed(wr_data[OFFSET_W-1:0]);
                REG_IDLE_TIMEOUT: idle_timeout_reg <= wr_data[TIMEOUT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg      <= PULSE_RST;
            moving_reg     <= 1'b0;
            step_value_reg <= '0;
            idle_ms_reg    <= '0;
            armed_reg      <= 1'b1;
            obs_ms_reg     <= '0;
            relax_ms_reg   <= '0;
            relaxed_reg    <= 1'b0;
        end
        else if (acc)
        begin
            pulse_reg      <= pulse_next;
            moving_reg     <= moving_next;
            step_value_reg <= step_value_next;
            idle_ms_reg    <= idle_ms_next;
            armed_reg      <= armed_next;
            obs_ms_reg     <= obs_ms_next;
            relax_ms_reg   <= relax_ms_next;
            relaxed_reg    <= relaxed_next;
        end
    end

    sgc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (buf_ready),
        .in_data   (res_d),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (res_q)
    );

    assign rsp.pulse_width    = res_q.pulse_width;
    assign rsp.pulse_write    = res_q.pulse_write;
    assign rsp.servo_angle    = res_q.servo_angle;
    assign rsp.feedback_angle = res_q.feedback_angle;
    assign rsp.obstacle       = res_q.obstacle;
    assign rsp.detached       = res_q.detached;
    assign rsp.relaxed        = res_q.relaxed;

    a_cmd_holds_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !is_tick) |=> (pulse_reg == $past(pulse_reg)))
        else $error("command item changed the pulse width");

    a_moving_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_tick && moving_reg) |=> (idle_ms_reg == '0))
        else $error("moving tick left the idle timer running");

    a_obstacle_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (res_d.obstacle || res_d.pulse_write)) |-> is_tick)
        else $error("command item reported an obstacle or a pulse write");

endmodule

// ===== test/servo_grip_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_grip_controller_unit_tb: self-checking bench for the grip controller
// Drives command and tick items with random gaps, stalls the result side at
// random and checks every result against a cycle-free predictor of the
// filter, angle mapping, obstacle, detach and relax logic. Several register
// settings are swept between phases, the extremes among them.
// ----------------------------------------------------------------------------

module servo_grip_controller_unit_tb;
    import sgc_pkg::*;

    localparam int FSHIFT       = FILTER_SHIFT_DEF;
    localparam int ANGLE_SHIFT  = GAIN_FRAC + FSHIFT;
    localparam int OFFSET_SHIFT = OFFSET_FRAC + FSHIFT;
    localparam int MAX_WAIT     = 18;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        action_t             act;
        logic [SAMPLE_W-1:0] sample;
        logic [MS_W-1:0]     ms;
    } grip_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    sgc_req_if req_ch ();
    sgc_rsp_if rsp_ch ();

    servo_grip_controller_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // register copies
    logic [PULSE_W-1:0]         cfg_pmin;
    logic [PULSE_W-1:0]         cfg_pmax;
    logic [STEP_W-1:0]          cfg_speed;
    logic                       cfg_side;
    logic signed [GAIN_W-1:0]   cfg_gain;
    logic signed [OFFSET_W-1:0] cfg_offset;
    logic [TIMEOUT_W-1:0]       cfg_timeout;

    // controller state copies
    logic [FILT_W-1:0]     filt_q;
    logic [PULSE_W-1:0]    pulse_q;
    logic                  moving_q;
    int                    step_q;
    logic [IDLE_W-1:0]     idle_q;
    logic                  armed_q;
    logic [OBS_MS_W-1:0]   obs_ms_q;
    logic [RELAX_MS_W-1:0] relax_q;
    logic                  relaxed_q;

    grip_item_t  pending_items[$];
    sgc_result_t expected_results[$];

    int  items_issued;
    int  items_accepted;
    int  mismatch_count;
    int  cycle_count;
    int  req_gap;
    int  rsp_hold;
    bit  req_taken;
    bit  req_calm;
    bit  rsp_calm;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int sat_sum(int a, int b, int top);
        return (a + b > top) ? top : a + b;
    endfunction

    function automatic int sign_of(int d);
        return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    endfunction

    // an inverted range resolves to pulse_min below it, else pulse_max above
    function automatic logic [PULSE_W-1:0] limit_pulse(int x);
        if (x < int'(cfg_pmin))
        begin
            return cfg_pmin;
        end
        if (x > int'(cfg_pmax))
        begin
            return cfg_pmax;
        end
        return PULSE_W'(x);
    endfunction

    function automatic int servo_angle_of(logic [PULSE_W-1:0] p);
        int pv;
        pv = int'(p);
        if (PULSE_AT_FULL <= PULSE_AT_ZERO)
        begin
            return (pv >= PULSE_AT_FULL) ? ANGLE_SPAN : 0;
        end
        if (pv <= PULSE_AT_ZERO)
        begin
            return 0;
        end
        if (pv >= PULSE_AT_FULL)
        begin
            return ANGLE_SPAN;
        end
        return (pv - PULSE_AT_ZERO) * ANGLE_SPAN / (PULSE_AT_FULL - PULSE_AT_ZERO);
    endfunction

    function automatic int feedback_angle_of();
        longint acc;
        longint scaled;
        acc = longint'(cfg_gain) * longint'(filt_q)
            + longint'(cfg_offset) * (longint'(1) <<< OFFSET_SHIFT);
        if (acc < 0)
        begin
            return 0;
        end
        scaled = acc >>> ANGLE_SHIFT;
        return (scaled > 255) ? 255 : int'(scaled);
    endfunction

    function automatic sgc_result_t advance_grip(action_t act, logic [SAMPLE_W-1:0] sample,
                                                 logic [MS_W-1:0] ms);
        sgc_result_t r;
        int          sang;
        int          fang;
        int          d;
        int          ad;
        bit          wr;
        bit          obs;
        bit          det;
        bit          plus;
        sang = servo_angle_of(pulse_q);
        wr   = 1'b0;
        obs  = 1'b0;
        idle_q  = IDLE_W'(sat_sum(int'(idle_q), int'(ms), (1 << IDLE_W) - 1));
        relax_q = RELAX_MS_W'(sat_sum(int'(relax_q), int'(ms), (1 << RELAX_MS_W) - 1));
        if (!armed_q)
        begin
            obs_ms_q = OBS_MS_W'(sat_sum(int'(obs_ms_q), int'(ms), (1 << OBS_MS_W) - 1));
        end
        if (act != ACT_TICK)
        begin
            if (act == ACT_STOP)
            begin
                moving_q = 1'b0;
                step_q   = 0;
            end
            else
            begin
                plus     = (act == ACT_OPEN) ? cfg_side : !cfg_side;
                moving_q = 1'b1;
                step_q   = plus ? int'(cfg_speed) : -int'(cfg_speed);
            end
            fang = feedback_angle_of();
            det  = idle_q > cfg_timeout;
        end
        else
        begin
            filt_q = filt_q + FILT_W'(sample) - (filt_q >> FSHIFT);
            fang   = feedback_angle_of();
            d      = sang - fang;
            ad     = (d < 0) ? -d : d;
            if (ad > OBSTACLE_DELTA_HARD)
            begin
                obs = 1'b1;
            end
            else if (ad > OBSTACLE_DELTA)
            begin
                if (armed_q)
                begin
                    obs_ms_q = '0;
                    armed_q  = 1'b0;
                end
                obs = obs_ms_q > OBSTACLE_HOLD_MS;
            end
            else
            begin
                armed_q = 1'b1;
            end
            if (moving_q)
            begin
                // step held back only when pushing into the obstacle
                if (!obs || sign_of(d) != step_q)
                begin
                    pulse_q = limit_pulse(int'(pulse_q) + step_q);
                end
                idle_q = '0;
            end
            det = idle_q > cfg_timeout;
            if (det)
            begin
                if (ad > RELAX_DELTA && !relaxed_q)
                begin
                    if (relax_q > RELAX_PERIOD_MS)
                    begin
                        pulse_q = limit_pulse(int'(pulse_q) - sign_of(d));
                        wr      = 1'b1;
                        relax_q = '0;
                    end
                end
                else
                begin
                    relaxed_q = 1'b1;
                end
            end
            else
            begin
                wr        = 1'b1;
                relaxed_q = 1'b0;
            end
        end
        r.pulse_width    = pulse_q;
        r.pulse_write    = wr;
        r.servo_angle    = ANGLE_W'(sang);
        r.feedback_angle = ANGLE_W'(fang);
        r.obstacle       = obs;
        r.detached       = det;
        r.relaxed        = relaxed_q;
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    task automatic push_item(action_t act, int sample, int ms);
        grip_item_t it;
        it.act    = act;
        it.sample = SAMPLE_W'(sample);
        it.ms     = MS_W'(ms);
        pending_items.push_back(it);
        items_issued++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (items_accepted != items_issued || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= CFG_DATA_W'(value);
        case (idx)
            REG_PULSE_MIN:    cfg_pmin    = PULSE_W'(value);
            REG_PULSE_MAX:    cfg_pmax    = PULSE_W'(value);
            REG_STEP_SPEED:   cfg_speed   = STEP_W'(value);
            REG_HAND_SIDE:    cfg_side    = value[0];
            REG_FB_GAIN:      cfg_gain    = GAIN_W'(value);
            REG_FB_OFFSET:    cfg_offset  = OFFSET_W'(value);
            REG_IDLE_TIMEOUT: cfg_timeout = TIMEOUT_W'(value);
            default:          ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // one item at a time so that ticks can steer the feedback angle to a chosen
    // distance from the servo angle
    task automatic run_phase(int count, bit idle_heavy);
        int      n;
        int      episode;
        int      delta;
        int      roll;
        int      mag;
        int      aim;
        int      sample;
        int      ms;
        action_t act;
        longint  ftar;
        longint  need;
        episode = 0;
        delta   = 0;
        for (n = 0; n < count; n++)
        begin
            @(posedge clk);
            #1;
            while (pending_items.size() != 0 || items_accepted != items_issued)
            begin
                @(posedge clk);
                #1;
            end
            if (episode == 0)
            begin
                episode = $urandom_range(5, 30);
                roll    = $urandom_range(0, 9);
                if (roll < 2)
                begin
                    mag = 0;
                end
                else if (roll < 4)
                begin
                    mag = $urandom_range(1, RELAX_DELTA);
                end
                else if (roll < 6)
                begin
                    mag = $urandom_range(RELAX_DELTA + 1, OBSTACLE_DELTA);
                end
                else if (roll < 9)
                begin
                    mag = $urandom_range(OBSTACLE_DELTA + 1, OBSTACLE_DELTA_HARD);
                end
                else
                begin
                    mag = $urandom_range(OBSTACLE_DELTA_HARD + 1, 60);
                end
                delta = $urandom_range(0, 1) ? mag : -mag;
            end
            episode--;
            roll = $urandom_range(0, 99);
            if (idle_heavy)
            begin
                act = (n == 0 || roll < 2) ? ACT_STOP : ACT_TICK;
                ms  = $urandom_range(200, 255);
            end
            else
            begin
                if (roll < 4)
                begin
                    act = ACT_OPEN;
                end
                else if (roll < 8)
                begin
                    act = ACT_CLOSE;
                end
                else if (roll < 12)
                begin
                    act = ACT_STOP;
                end
                else
                begin
                    act = ACT_TICK;
                end
                ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 255);
            end
            roll = $urandom_range(0, 99);
            if (act == ACT_TICK && cfg_gain > 0 && roll < 60)
            begin
                aim = servo_angle_of(pulse_q) + delta;
                aim = (aim < 0) ? 0 : ((aim > 255) ? 255 : aim);
                ftar = ((longint'(aim) <<< ANGLE_SHIFT) + (longint'(1) <<< (ANGLE_SHIFT - 1))
                       - longint'(cfg_offset) * (longint'(1) <<< OFFSET_SHIFT))
                       / longint'(cfg_gain);
                if (ftar < 0)
                begin
                    ftar = 0;
                end
                if (ftar > (longint'(1) <<< FILT_W) - 1)
                begin
                    ftar = (longint'(1) <<< FILT_W) - 1;
                end
                need = ftar - longint'(filt_q) + longint'(filt_q >> FSHIFT);
                if (need < 0)
                begin
                    need = 0;
                end
                if (need > (1 << SAMPLE_W) - 1)
                begin
                    need = (1 << SAMPLE_W) - 1;
                end
                sample = int'(need);
            end
            else if (roll < 85)
            begin
                sample = $urandom_range(0, (1 << SAMPLE_W) - 1);
            end
            else
            begin
                sample = $urandom_range(0, 1) ? (1 << SAMPLE_W) - 1 : 0;
            end
            push_item(act, sample, ms);
        end
    endtask

    // request side: one item per transfer, random gap before each next item
    always @(negedge clk)
    begin : drive_req
        grip_item_t it;
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                req_taken = 1'b0;
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    it = pending_items.pop_front();
                    req_ch.action          <= it.act;
                    req_ch.feedback_sample <= it.sample;
                    req_ch.ms_elapsed      <= it.ms;
                    req_ch.valid           <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                    begin
                        req_calm = !req_calm;
                    end
                    req_gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : take_req
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            expected_results.push_back(advance_grip(action_t'(req_ch.action),
                                                    req_ch.feedback_sample,
                                                    req_ch.ms_elapsed));
            items_accepted++;
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : drive_rsp_ready
        if (rst_n)
        begin
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        sgc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding, pulse_width", 0,
                                rsp_ch.pulse_width);
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.pulse_width !== want.pulse_width)
                begin
                    report_mismatch("pulse_width", want.pulse_width, rsp_ch.pulse_width);
                end
                if (rsp_ch.pulse_write !== want.pulse_write)
                begin
                    report_mismatch("pulse_write", want.pulse_write, rsp_ch.pulse_write);
                end
                if (rsp_ch.servo_angle !== want.servo_angle)
                begin
                    report_mismatch("servo_angle", want.servo_angle, rsp_ch.servo_angle);
                end
                if (rsp_ch.feedback_angle !== want.feedback_angle)
                begin
                    report_mismatch("feedback_angle", want.feedback_angle,
                                    rsp_ch.feedback_angle);
                end
                if (rsp_ch.obstacle !== want.obstacle)
                begin
                    report_mismatch("obstacle", want.obstacle, rsp_ch.obstacle);
                end
                if (rsp_ch.detached !== want.detached)
                begin
                    report_mismatch("detached", want.detached, rsp_ch.detached);
                end
                if (rsp_ch.relaxed !== want.relaxed)
                begin
                    report_mismatch("relaxed", want.relaxed, rsp_ch.relaxed);
                end
            end
            if ($urandom_range(0, 39) == 0)
            begin
                rsp_calm = !rsp_calm;
            end
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout: %0d items accepted of %0d, %0d results outstanding",
                     items_accepted, items_issued, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        rst_n                  = 1'b0;
        wr_en                  = 1'b0;
        wr_index               = '0;
        wr_data                = '0;
        req_ch.valid           = 1'b0;
        req_ch.action          = ACT_TICK;
        req_ch.feedback_sample = '0;
        req_ch.ms_elapsed      = '0;
        rsp_ch.ready           = 1'b0;
        items_issued   = 0;
        items_accepted = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        req_gap        = 0;
        rsp_hold       = 0;
        req_taken      = 1'b0;
        req_calm       = 1'b0;
        rsp_calm       = 1'b0;

        cfg_pmin    = PULSE_MIN_RST;
        cfg_pmax    = PULSE_MAX_RST;
        cfg_speed   = STEP_SPEED_RST;
        cfg_side    = 1'b0;
        cfg_gain    = '0;
        cfg_offset  = '0;
        cfg_timeout = IDLE_TIMEOUT_RST;
        filt_q      = '0;
        pulse_q     = PULSE_RST;
        moving_q    = 1'b0;
        step_q      = 0;
        idle_q      = '0;
        armed_q     = 1'b1;
        obs_ms_q    = '0;
        relax_q     = '0;
        relaxed_q   = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, every action, detach and back-off
        push_item(ACT_TICK, 0, 0);
        push_item(ACT_TICK, 4095, 255);
        push_item(ACT_OPEN, 4095, 255);
        push_item(ACT_TICK, 2048, 1);
        push_item(ACT_TICK, 4095, 0);
        push_item(ACT_CLOSE, 1, 0);
        push_item(ACT_TICK, 0, 255);
        push_item(ACT_TICK, 2730, 128);
        push_item(ACT_STOP, 0, 255);
        push_item(ACT_TICK, 0, 255);
        push_item(ACT_TICK, 4095, 255);
        push_item(ACT_TICK, 1365, 255);
        push_item(ACT_TICK, 0, 255);
        push_item(ACT_TICK, 4095, 51);
        push_item(ACT_TICK, 0, 50);
        push_item(ACT_TICK, 4095, 255);
        push_item(ACT_OPEN, 0, 7);
        push_item(ACT_TICK, 1000, 20);
        push_item(ACT_STOP, 4095, 0);
        push_item(ACT_TICK, 3000, 200);

        for (ph = 1; ph <= 9; ph++)
        begin
            wait_idle();
            case (ph)
                1:
                begin
                    write_reg(REG_PULSE_MIN, PULSE_AT_ZERO);
                    write_reg(REG_PULSE_MAX, PULSE_AT_FULL);
                    write_reg(REG_STEP_SPEED, 5);
                    write_reg(REG_HAND_SIDE, 0);
                    write_reg(REG_FB_GAIN, 2881);
                    write_reg(REG_FB_OFFSET, 0);
                    write_reg(REG_IDLE_TIMEOUT, 800);
                end
                2:
                begin
                    write_reg(REG_PULSE_MIN, 0);
                    write_reg(REG_PULSE_MAX, 3000);
                    write_reg(REG_STEP_SPEED, 255);
                    write_reg(REG_HAND_SIDE, 1);
                    write_reg(REG_IDLE_TIMEOUT, 0);
                end
                3:
                begin
                    // inverted limits
                    write_reg(REG_PULSE_MIN, 1800);
                    write_reg(REG_PULSE_MAX, 1200);
                    write_reg(REG_STEP_SPEED, 20);
                    write_reg(REG_HAND_SIDE, 0);
                    write_reg(REG_IDLE_TIMEOUT, 300);
                end
                4:
                begin
                    // long stop so the idle timer saturates against the top timeout
                    write_reg(REG_PULSE_MIN, 1000);
                    write_reg(REG_PULSE_MAX, 2000);
                    write_reg(REG_STEP_SPEED, 0);
                    write_reg(REG_FB_OFFSET, 128);
                    write_reg(REG_IDLE_TIMEOUT, 65535);
                end
                5:
                begin
                    write_reg(REG_PULSE_MIN, 600);
                    write_reg(REG_PULSE_MAX, 2300);
                    write_reg(REG_STEP_SPEED, 37);
                    write_reg(REG_HAND_SIDE, 1);
                    write_reg(REG_FB_GAIN, 8388607);
                    write_reg(REG_FB_OFFSET, -65536);
                    write_reg(REG_IDLE_TIMEOUT, 2000);
                end
                6:
                begin
                    // unit steps: a blocked step has the sign of the angle error
                    write_reg(REG_PULSE_MIN, 1300);
                    write_reg(REG_PULSE_MAX, 1700);
                    write_reg(REG_STEP_SPEED, 1);
                    write_reg(REG_HAND_SIDE, 0);
                    write_reg(REG_FB_GAIN, 2881);
                    write_reg(REG_FB_OFFSET, -640);
                    write_reg(REG_IDLE_TIMEOUT, 500);
                end
                7:
                begin
                    write_reg(REG_PULSE_MIN, $urandom_range(0, 3000));
                    write_reg(REG_PULSE_MAX, $urandom_range(0, 3000));
                    write_reg(REG_STEP_SPEED, $urandom_range(0, 8));
                    write_reg(REG_HAND_SIDE, $urandom_range(0, 1));
                    write_reg(REG_FB_GAIN, $urandom_range(2000, 4000));
                    write_reg(REG_FB_OFFSET, int'($urandom_range(0, 4000)) - 2000);
                    write_reg(REG_IDLE_TIMEOUT, $urandom_range(0, 3000));
                end
                8:
                begin
                    write_reg(REG_PULSE_MIN, 1500);
                    write_reg(REG_PULSE_MAX, 1500);
                    write_reg(REG_STEP_SPEED, 255);
                    write_reg(REG_HAND_SIDE, 1);
                    write_reg(REG_FB_GAIN, -8388608);
                    write_reg(REG_FB_OFFSET, 65535);
                    write_reg(REG_IDLE_TIMEOUT, 100);
                end
                default:
                begin
                    write_reg(REG_PULSE_MIN, $urandom_range(0, 3000));
                    write_reg(REG_PULSE_MAX, $urandom_range(0, 3000));
                    write_reg(REG_STEP_SPEED, $urandom_range(0, 255));
                    write_reg(REG_HAND_SIDE, $urandom_range(0, 1));
                    write_reg(REG_FB_GAIN, int'($urandom_range(0, (1 << GAIN_W) - 1))
                                           - (1 << (GAIN_W - 1)));
                    write_reg(REG_FB_OFFSET, int'($urandom_range(0, (1 << OFFSET_W) - 1))
                                             - (1 << (OFFSET_W - 1)));
                    write_reg(REG_IDLE_TIMEOUT, $urandom_range(0, 65535));
                end
            endcase
            run_phase((ph == 4) ? 330 : 100, ph == 4);
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
